// ----- design/ptsm_pkg.sv -----
// shared types and constant functions of the pan/tilt shape modulator
// no dependencies
package ptsm_pkg;

  localparam int ShapeW = 3;
  localparam logic [ShapeW-1:0] ShapeCircle = 3'd0;
  localparam logic [ShapeW-1:0] ShapeFig8   = 3'd1;
  localparam logic [ShapeW-1:0] ShapeTri    = 3'd2;
  localparam logic [ShapeW-1:0] ShapeSquare = 3'd3;
  localparam logic [ShapeW-1:0] ShapeHLine  = 3'd4;
  localparam logic [ShapeW-1:0] ShapeVLine  = 3'd5;

  localparam int InDataW  = 120;
  localparam int OutDataW = 32;
  localparam int RecipShift = 28;

  localparam longint Q30One    = 64'sd1073741824;
  localparam longint Q30HalfPi = 64'sd1686629713;

  typedef struct packed {
    logic [ShapeW-1:0] shape_type;
    logic [15:0]       size_x;
    logic [15:0]       size_y;
    logic [15:0]       pan_base;
    logic [15:0]       tilt_base;
    logic              pan_fine;
    logic              tilt_fine;
  } ptsm_pay_t;

  function automatic longint sq_step(input longint term, input longint x);
    longint t;
    t = (term * x) / Q30One;
    t = (t * x) / Q30One;
    return t;
  endfunction

  // quarter-wave sine entry from a q30 angle, q1.15 result
  function automatic logic [16:0] sine_entry(input longint x);
    longint term;
    longint sum;
    longint v;
    term = x;
    sum  = x;
    term = -sq_step(term, x) / 6;   sum += term;
    term = -sq_step(term, x) / 20;  sum += term;
    term = -sq_step(term, x) / 42;  sum += term;
    term = -sq_step(term, x) / 72;  sum += term;
    term = -sq_step(term, x) / 110; sum += term;
    term = -sq_step(term, x) / 156; sum += term;
    term = -sq_step(term, x) / 210; sum += term;
    term = -sq_step(term, x) / 272; sum += term;
    term = -sq_step(term, x) / 342; sum += term;
    term = -sq_step(term, x) / 420; sum += term;
    term = -sq_step(term, x) / 506; sum += term;
    term = -sq_step(term, x) / 600; sum += term;
    if (sum < 0) sum = 0;
    v = (sum * 64'sd32768 + 64'sd536870912) >>> 30;
    if (v > 64'sd32768) v = 64'sd32768;
    return v[16:0];
  endfunction

endpackage

// ----- design/pan_tilt_shape_modulator.sv -----
// pan/tilt shape modulator: six-stage pipeline from fixture word to pan/tilt word
// depends on ptsm_pkg
//
// One input word gives one output word. The pipeline is six register stages deep
// (spread product, reciprocal multiply, quotient fix and phase, waveform and sine
// lookup, size multiply, scale and clamp), and a new word is taken every cycle
// unless the output stalls. The whole pipeline moves together: it holds only
// while the output word waits and m_axis_tready is low. The divide by the fixture
// count is a multiply by a constant reciprocal plus one correction step. The sine
// comes from a constant quarter-wave table of SINE_TABLE_DEPTH+1 entries.
module pan_tilt_shape_modulator #(
  parameter int FIXTURE_LIMIT    = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // shape_type[2:0], current_phase[18:3], phase_spread[35:19], fixture_position[40:36],
  // fixture_count[46:41], size_x[62:47], size_y[78:63], pan_base[94:79],
  // tilt_base[110:95], pan_fine[111], tilt_fine[112], zero fill
  input  logic [ptsm_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pan_value[15:0], tilt_value[31:16]
  output logic [ptsm_pkg::OutDataW-1:0] m_axis_tdata
);
  import ptsm_pkg::*;

  localparam int IdxW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int RecW = RecipShift + 1;

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // constant tables
  logic [16:0] sine_lut [SINE_TABLE_DEPTH+1];
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
    localparam longint X = (Q30HalfPi * k) / SINE_TABLE_DEPTH;
    assign sine_lut[k] = sine_entry(X);
  end
  logic [RecW-1:0] recip_lut [64];
  for (genvar c = 0; c < 64; c++) begin : g_recip
    localparam longint R = (c == 0) ? 0 : (64'sd1 <<< RecipShift) / ((c == 0) ? 1 : c);
    assign recip_lut[c] = R[RecW-1:0];
  end

  // stage 1: spread product and count fix-up
  ptsm_pay_t   pay_in;
  logic [6:0]  cnt_in;
  logic [5:0]  cnt_sat;
  assign pay_in = '{shape_type: s_axis_tdata[2:0], size_x: s_axis_tdata[62:47],
                    size_y: s_axis_tdata[78:63], pan_base: s_axis_tdata[94:79],
                    tilt_base: s_axis_tdata[110:95], pan_fine: s_axis_tdata[111],
                    tilt_fine: s_axis_tdata[112]};
  always_comb begin
    cnt_in = {1'b0, s_axis_tdata[46:41]};
    if (cnt_in == 7'd0) cnt_in = 7'd1;
    if (cnt_in > 7'(FIXTURE_LIMIT)) cnt_in = 7'(FIXTURE_LIMIT);
    cnt_sat = cnt_in[5:0];
  end

  logic        v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [21:0] prod1_q, prod2_q;
  logic [5:0]  cnt1_q, cnt2_q;
  logic [15:0] cur1_q, cur2_q;
  ptsm_pay_t   pay1_q, pay2_q, pay3_q, pay4_q;
  logic [21+RecW:0] qe2_q;
  logic [15:0] p3_q;
  logic signed [16:0] pw4_q, tw4_q;
  logic signed [33:0] pm5_q, tm5_q;
  logic [15:0] pb5_q, tb5_q;
  logic        pf5_q, tf5_q;
  logic [15:0] pan_q, tilt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid; v2_q <= v1_q; v3_q <= v2_q;
      v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod1_q <= 22'(s_axis_tdata[35:19]) * 22'(s_axis_tdata[40:36]);
      cnt1_q  <= cnt_sat;
      cur1_q  <= s_axis_tdata[18:3];
      pay1_q  <= pay_in;
    end
  end

  // stage 2: multiply by reciprocal of count
  always_ff @(posedge clk_i) begin
    if (adv) begin
      qe2_q   <= prod1_q * recip_lut[cnt1_q];
      prod2_q <= prod1_q;
      cnt2_q  <= cnt1_q;
      cur2_q  <= cur1_q;
      pay2_q  <= pay1_q;
    end
  end

  // stage 3: quotient correction and fixture phase
  logic [21:0] q0, q;
  logic [22:0] rem;
  always_comb begin
    q0  = qe2_q[RecipShift +: 22];
    rem = {1'b0, prod2_q} - 23'(q0 * cnt2_q);
    q   = (rem >= {17'd0, cnt2_q}) ? q0 + 22'd1 : q0;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_q   <= cur2_q + q[15:0];
      pay3_q <= pay2_q;
    end
  end

  // stage 4: waveforms
  function automatic logic signed [16:0] tsine(input logic [15:0] p,
                                               input logic [16:0] e);
    return p[15] ? -$signed(e) : $signed(e);
  endfunction
  function automatic logic [IdxW-1:0] sidx(input logic [15:0] p);
    logic [14:0] arg;
    logic [IdxW+14:0] m;
    arg = p[14] ? 15'd16384 - {1'b0, p[13:0]} : {1'b0, p[13:0]};
    m = (IdxW+15)'(arg * SINE_TABLE_DEPTH) >> 14;
    if (m > (IdxW+15)'(SINE_TABLE_DEPTH)) m = (IdxW+15)'(SINE_TABLE_DEPTH);
    return m[IdxW-1:0];
  endfunction

  logic [15:0] pt;
  logic signed [16:0] s_a, s_b, pw, tw, f_t, f_s;
  logic [17:0] p3x;
  always_comb begin
    pt  = (pay3_q.shape_type == ShapeCircle) ? p3_q + 16'd16384 : {p3_q[14:0], 1'b0};
    s_a = tsine(p3_q, sine_lut[sidx(p3_q)]);
    s_b = tsine(pt, sine_lut[sidx(pt)]);
    p3x = 18'(p3_q) * 18'd3;
    f_t = {1'b0, p3x[15:0]};
    f_s = {1'b0, p3_q[13:0], 2'b00};
    pw  = '0;
    tw  = '0;
    unique case (pay3_q.shape_type)
      ShapeCircle, ShapeFig8: begin
        pw = s_a; tw = s_b;
      end
      ShapeTri: begin
        unique case (p3x[17:16])
          2'd0: begin pw = -17'sd32768 + f_t; tw = -17'sd32768; end
          2'd1: begin pw = 17'sd32768 - (f_t >>> 1); tw = -17'sd32768 + f_t; end
          default: begin pw = -(f_t >>> 1); tw = 17'sd32768 - f_t; end
        endcase
      end
      ShapeSquare: begin
        unique case (p3_q[15:14])
          2'd0: begin pw = -17'sd32768 + f_s; tw = -17'sd32768; end
          2'd1: begin pw = 17'sd32768; tw = -17'sd32768 + f_s; end
          2'd2: begin pw = 17'sd32768 - f_s; tw = 17'sd32768; end
          default: begin pw = -17'sd32768; tw = 17'sd32768 - f_s; end
        endcase
      end
      ShapeHLine: pw = s_a;
      ShapeVLine: tw = s_a;
      default: ;
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pw4_q  <= pw;
      tw4_q  <= tw;
      pay4_q <= pay3_q;
    end
  end

  // stage 5: size multiply
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pm5_q <= 34'(pw4_q) * 34'($signed({1'b0, pay4_q.size_x}));
      tm5_q <= 34'(tw4_q) * 34'($signed({1'b0, pay4_q.size_y}));
      pb5_q <= pay4_q.pan_base;
      tb5_q <= pay4_q.tilt_base;
      pf5_q <= pay4_q.pan_fine;
      tf5_q <= pay4_q.tilt_fine;
    end
  end

  // stage 6: scale by shift-subtract, add base, clamp
  function automatic logic [15:0] finish(input logic signed [33:0] m,
                                         input logic [15:0] base, input logic fine);
    logic signed [51:0] mx, sc, num;
    logic [15:0] b;
    logic [20:0] r;
    mx  = 52'(m);
    sc  = fine ? (mx <<< 16) - mx : (mx <<< 8) - mx;
    b   = fine ? base : {8'd0, base[7:0]};
    num = $signed({5'd0, b, 31'd0}) + sc;
    r   = num[51:31];
    if (num < 0) return 16'd0;
    if (fine) return (r > 21'd65535) ? 16'hFFFF : r[15:0];
    return (r > 21'd255) ? 16'd255 : r[15:0];
  endfunction
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pan_q  <= finish(pm5_q, pb5_q, pf5_q);
      tilt_q <= finish(tm5_q, tb5_q, tf5_q);
    end
  end

  assign m_axis_tvalid = v6_q;
  assign m_axis_tdata  = {tilt_q, pan_q};

  // corrected quotient always lands within one of the estimate
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> rem < {16'd0, cnt2_q, 1'b0}) else $error("quotient estimate off");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word lost on stall");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q) else $error("accepted word dropped");
endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for the pan/tilt shape modulator: directed and random fixture words,
// own predictor of phase, waveform and clamped scaling, scoreboard class for checks
// depends on ptsm_pkg and pan_tilt_shape_modulator
`timescale 1ns / 1ps

module tb_top;
  import ptsm_pkg::*;

  typedef struct packed {
    logic [2:0]  shape;
    logic [15:0] cur;
    logic [16:0] spread;
    logic [4:0]  pos;
    logic [5:0]  cnt;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] pb;
    logic [15:0] tb;
    logic        pf;
    logic        tf;
  } fix_t;

  typedef struct packed {
    logic [15:0] pan;
    logic [15:0] tilt;
  } pt_t;

  class pt_scoreboard;
    pt_t         pending[$];
    int          errors;
    int          quarter[0:256];

    function new();
      longint x, term, sum, v;
      errors = 0;
      for (int k = 0; k <= 256; k++) begin
        x = (Q30HalfPi * k) / 256;
        term = x;
        sum = x;
        for (int n = 1; n <= 12; n++) begin
          term = (term * x) / Q30One;
          term = (term * x) / Q30One;
          term = -term / ((2 * n) * (2 * n + 1));
          sum += term;
        end
        if (sum < 0) sum = 0;
        v = (sum * 32768 + 536870912) >>> 30;
        if (v > 32768) v = 32768;
        quarter[k] = int'(v);
      end
    endfunction

    function int tsin(logic [15:0] p);
      logic [1:0] quad;
      int frac, arg, idx;
      quad = p[15:14];
      frac = p[13:0];
      arg = quad[0] ? 16384 - frac : frac;
      idx = (arg * 256) >> 14;
      if (idx > 256) idx = 256;
      return quad[1] ? -quarter[idx] : quarter[idx];
    endfunction

    function logic [15:0] scale(logic [15:0] base, logic fine, int wave, logic [15:0] size);
      longint b, num, r, top;
      top = fine ? 65535 : 255;
      b = fine ? longint'(base) : longint'(base[7:0]);
      num = b * 64'sd2147483648 + longint'(wave) * longint'(size) * top;
      if (num < 0) return 16'd0;
      r = num >>> 31;
      if (r > top) r = top;
      return r[15:0];
    endfunction

    function void note_input(fix_t w);
      int cnt, pw, tw, f;
      logic [31:0] prod;
      logic [15:0] p;
      pt_t e;
      cnt = w.cnt;
      if (cnt == 0) cnt = 1;
      if (cnt > 32) cnt = 32;
      p = 16'((32'(w.cur) + (32'(w.spread) * 32'(w.pos)) / cnt));
      pw = 0;
      tw = 0;
      case (w.shape)
        ShapeCircle: begin
          pw = tsin(p);
          tw = tsin(p + 16'd16384);
        end
        ShapeFig8: begin
          pw = tsin(p);
          tw = tsin({p[14:0], 1'b0});
        end
        ShapeTri: begin
          prod = 32'(p) * 3;
          f = prod[15:0];
          if (prod[31:16] == 0) begin
            pw = -32768 + f;
            tw = -32768;
          end else if (prod[31:16] == 1) begin
            pw = 32768 - f / 2;
            tw = -32768 + f;
          end else begin
            pw = -(f / 2);
            tw = 32768 - f;
          end
        end
        ShapeSquare: begin
          prod = 32'(p) * 4;
          f = prod[15:0];
          case (prod[17:16])
            2'd0: begin pw = -32768 + f; tw = -32768; end
            2'd1: begin pw = 32768; tw = -32768 + f; end
            2'd2: begin pw = 32768 - f; tw = 32768; end
            default: begin pw = -32768; tw = 32768 - f; end
          endcase
        end
        ShapeHLine: pw = tsin(p);
        ShapeVLine: tw = tsin(p);
        default: ;
      endcase
      e.pan = scale(w.pb, w.pf, pw, w.sx);
      e.tilt = scale(w.tb, w.tf, tw, w.sy);
      pending.push_back(e);
    endfunction

    function void check_result(pt_t got);
      pt_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.pan !== e.pan || got.tilt !== e.tilt) begin
        errors++;
        if (errors <= 10)
          $display("mismatch pan exp %h got %h, tilt exp %h got %h",
                   e.pan, got.pan, e.tilt, got.tilt);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;

  pt_scoreboard sb = new();
  int src_idle = 0;
  int snk_stall = 0;
  int hold_off = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  always #2 clk_i = ~clk_i;

  pan_tilt_shape_modulator DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // output side: stall at random, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result({m_axis_tdata[15:0], m_axis_tdata[31:16]});
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_off <= 60;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall);
    end
  end

  function automatic fix_t rand_word();
    fix_t w;
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    w = r[$bits(fix_t)-1:0];
    if ($urandom_range(3) != 0) w.shape = 3'($urandom_range(5));
    if ($urandom_range(3) != 0) w.spread = 17'($urandom_range(65536));
    if ($urandom_range(3) != 0) w.cnt = 6'($urandom_range(1, 32));
    if ($urandom_range(3) != 0) w.pos = 5'($urandom_range(w.cnt == 0 ? 0 : w.cnt - 1));
    if ($urandom_range(3) != 0) w.sx = 16'($urandom_range(32768));
    if ($urandom_range(3) != 0) w.sy = 16'($urandom_range(32768));
    return w;
  endfunction

  task automatic send(fix_t w);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, w.tf, w.pf, w.tb, w.pb, w.sy, w.sx, w.cnt, w.pos,
                     w.spread, w.cur, w.shape};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(w);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  initial begin
    fix_t w;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 24; i++) begin
      w = '0;
      w.shape = 3'(i % 8);
      w.cur = 16'((i * 11000) & 16'hffff);
      w.cnt = (i == 9) ? 6'd0 : (i == 10) ? 6'd63 : 6'd4;
      w.pos = (i == 11) ? 5'd31 : 5'(i % 4);
      w.spread = (i == 12) ? 17'h1ffff : 17'd65536;
      w.sx = (i == 13) ? 16'hffff : (i % 3 == 0) ? 16'd32768 : 16'd0;
      w.sy = (i == 14) ? 16'hffff : 16'd32768;
      w.pb = (i % 2) ? 16'hffff : 16'h0000;
      w.tb = (i == 15) ? 16'h1234 : 16'h8000;
      w.pf = i[1];
      w.tf = i[2];
      send(w);
    end
    for (int ph = 0; ph < 4; ph++) begin
      src_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 85 : 24) : 0;
      snk_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 85 : 24) : 0;
      if (ph == 0) hold_req <= 1'b1;
      for (int i = 0; i < 250; i++) send(rand_word());
      drain();
    end
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
